>>> sv/tap_double_hold_classifier_unit_macros.svh
// Assertion macros for the tap/double-tap/hold classifier.
`ifndef TAP_DOUBLE_HOLD_CLASSIFIER_UNIT_MACROS_SVH
`define TAP_DOUBLE_HOLD_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define THDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("thdc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define THDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thdc next-cycle check failed");

`endif

>>> sv/thdc_pkg.sv
// Shared types, constants and helpers for the tap/double-tap/hold classifier.
package thdc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned KIND_W   = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd300;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_POLL    = 2'd2,
        KIND_FLUSH   = 2'd3
    } kind_t;

    typedef struct packed {
        logic hold_end;
        logic hold_start;
        logic double_tap;
        logic tap;
    } action_t;

    // Wrap-safe: reached when (now - deadline) has its top bit clear.
    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return ~diff[TIME_W-1];
    endfunction

endpackage

>>> sv/thdc_core.sv
// Button state, window register and event classification logic.
`include "tap_double_hold_classifier_unit_macros.svh"

module thdc_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [thdc_pkg::WINDOW_W-1:0]     cfg_wdata,
    input  logic                              step,
    input  thdc_pkg::kind_t                   kind,
    input  logic [thdc_pkg::TIME_W-1:0]       now_ms,
    output thdc_pkg::action_t                 act
);

    logic [thdc_pkg::WINDOW_W-1:0] window_reg;
    logic                          is_down_reg, is_down_next;
    logic                          awaiting_reg, awaiting_next;
    logic                          second_reg, second_next;
    logic                          hold_sent_reg, hold_sent_next;
    logic [thdc_pkg::TIME_W-1:0]   press_time_reg, press_time_next;
    logic [thdc_pkg::TIME_W-1:0]   deadline_reg, deadline_next;
    logic [thdc_pkg::TIME_W-1:0]   window_ext;
    logic [thdc_pkg::TIME_W-1:0]   hold_diff;
    logic                          hold_due;
    logic                          deadline_due;
    logic                          flags_clear;

    assign window_ext   = {{(thdc_pkg::TIME_W-thdc_pkg::WINDOW_W){1'b0}}, window_reg};
    assign hold_diff    = now_ms - press_time_reg - window_ext;
    assign hold_due     = ~hold_diff[thdc_pkg::TIME_W-1];
    assign deadline_due = thdc_pkg::time_reached(now_ms, deadline_reg);
    assign flags_clear  = !is_down_reg && !awaiting_reg && !second_reg && !hold_sent_reg;

    always_comb begin
        is_down_next    = is_down_reg;
        awaiting_next   = awaiting_reg;
        second_next     = second_reg;
        hold_sent_next  = hold_sent_reg;
        press_time_next = press_time_reg;
        deadline_next   = deadline_reg;
        act             = '0;
        if (step) begin
            case (kind)
                thdc_pkg::KIND_PRESS: begin
                    if (!is_down_reg) begin
                        if (awaiting_reg && deadline_due) begin
                            awaiting_next  = 1'b0;
                            second_next    = 1'b0;
                            hold_sent_next = 1'b0;
                            deadline_next  = '0;
                            act.tap        = 1'b1;
                        end else begin
                            second_next   = awaiting_reg;
                            awaiting_next = 1'b0;
                        end
                        is_down_next    = 1'b1;
                        press_time_next = now_ms;
                    end
                end
                thdc_pkg::KIND_RELEASE: begin
                    if (is_down_reg) begin
                        is_down_next = 1'b0;
                        if (hold_sent_reg || second_reg) begin
                            awaiting_next   = 1'b0;
                            second_next     = 1'b0;
                            hold_sent_next  = 1'b0;
                            press_time_next = '0;
                            deadline_next   = '0;
                            act.hold_end    = hold_sent_reg;
                            act.double_tap  = ~hold_sent_reg;
                        end else begin
                            awaiting_next = 1'b1;
                            deadline_next = now_ms + window_ext;
                        end
                    end
                end
                thdc_pkg::KIND_POLL: begin
                    if (is_down_reg && !hold_sent_reg && hold_due) begin
                        act.hold_start = 1'b1;
                        act.tap        = second_reg;
                        hold_sent_next = 1'b1;
                        awaiting_next  = 1'b0;
                    end else if (awaiting_reg && deadline_due) begin
                        is_down_next    = 1'b0;
                        awaiting_next   = 1'b0;
                        second_next     = 1'b0;
                        hold_sent_next  = 1'b0;
                        press_time_next = '0;
                        deadline_next   = '0;
                        act.tap         = 1'b1;
                    end
                end
                thdc_pkg::KIND_FLUSH: begin
                    act.hold_end    = hold_sent_reg;
                    act.tap         = ~hold_sent_reg & (awaiting_reg | second_reg);
                    is_down_next    = 1'b0;
                    awaiting_next   = 1'b0;
                    second_next     = 1'b0;
                    hold_sent_next  = 1'b0;
                    press_time_next = '0;
                    deadline_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= thdc_pkg::WINDOW_RESET;
            is_down_reg    <= 1'b0;
            awaiting_reg   <= 1'b0;
            second_reg     <= 1'b0;
            hold_sent_reg  <= 1'b0;
            press_time_reg <= '0;
            deadline_reg   <= '0;
        end else begin
            if (cfg_wen) begin
                window_reg <= cfg_wdata;
            end
            is_down_reg    <= is_down_next;
            awaiting_reg   <= awaiting_next;
            second_reg     <= second_next;
            hold_sent_reg  <= hold_sent_next;
            press_time_reg <= press_time_next;
            deadline_reg   <= deadline_next;
        end
    end

    `THDC_ASSERT_NOW(a_hold_needs_down, hold_sent_reg, is_down_reg)
    `THDC_ASSERT_NOW(a_await_while_up, awaiting_reg, !is_down_reg && !second_reg)
    `THDC_ASSERT_NOW(a_second_needs_down, second_reg, is_down_reg)
    `THDC_ASSERT_NEXT(a_flush_clears, step && kind == thdc_pkg::KIND_FLUSH, flags_clear)

endmodule

>>> sv/tap_double_hold_classifier_unit.sv
// Top level of the tap/double-tap/hold classifier with stream ports.
// Each accepted word passes through the input register, then the result register.
// Throughput: one word per cycle unless m_tready holds the result; classification and state update happen in one pass.
// While a result word waits for m_tready, one more word enters the input register.
// Reset (aresetn low, synchronous): all button state clears, window_ms returns to 300,
// both stages empty.
module tap_double_hold_classifier_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,   // window_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] now_ms
    input  logic [1:0]  s_tuser,     // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // [0] tap, [1] double_tap, [2] hold_start, [3] hold_end
);

    logic                        in_vld_reg, in_vld_next;
    thdc_pkg::kind_t             in_kind_reg;
    logic [thdc_pkg::TIME_W-1:0] in_now_reg;
    logic                        out_vld_reg, out_vld_next;
    thdc_pkg::action_t           out_act_reg;
    thdc_pkg::action_t           core_act;
    logic                        adv;
    logic                        s_take;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (adv) begin
            in_vld_next = 1'b0;
        end
        if (s_take) begin
            in_vld_next = 1'b1;
        end
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        if (adv) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // hold payload until the stage advances
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_kind_reg <= thdc_pkg::kind_t'(s_tuser);
            in_now_reg  <= s_tdata;
        end
        if (adv) begin
            out_act_reg <= core_act;
        end
    end

    thdc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .step      (adv),
        .kind      (in_kind_reg),
        .now_ms    (in_now_reg),
        .act       (core_act)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_act_reg.hold_end, out_act_reg.hold_start,
                       out_act_reg.double_tap, out_act_reg.tap};

endmodule
